FILE: design/text_console_writer_top_macros.svh
// Assertion macros for the text console writer.
// Under SYNTHESIS they expand to nothing.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define TXC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("txc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define TXC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("txc: next-cycle check failed");

`else

`define TXC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TXC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/txc_pkg.sv
`timescale 1ns / 1ps

package txc_pkg;

	// Default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Field widths
	localparam int OP_W    = 2;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;

	// Stream data widths, whole bytes
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	// Cell and register values
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	// Control characters
	localparam logic [CHAR_W-1:0] CHAR_NL = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_BS = 8'd8;

	// Operation codes carried on tuser
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture the accepted item
		logic put;       // write or step for one character
		logic copy;      // one step of the scroll copy
		logic sweep;     // blank one cell and advance
		logic out_load;  // load the result register
	} txc_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [OP_W-1:0] in_op;      // op of the item on the input
		logic            put_wraps;  // this put runs off the last row
		logic            copy_last;  // last cell of the scroll copy
		logic            sweep_last; // last cell of the blanking sweep
	} txc_sts_t;

endpackage

FILE: design/txc_ram.sv
`timescale 1ns / 1ps

module txc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/txc_datapath.sv
`timescale 1ns / 1ps

module txc_datapath #(
	parameter int COLUMNS = txc_pkg::COLUMNS_DEF,
	parameter int ROWS    = txc_pkg::ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [txc_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [txc_pkg::OP_W-1:0]   s_tuser,
	input  logic                       cfg_we,
	input  logic [txc_pkg::ATTR_W-1:0] cfg_wdata,
	output logic [txc_pkg::M_DATA_W-1:0] m_tdata,
	input  txc_pkg::txc_ctl_t          ctl,
	output txc_pkg::txc_sts_t          sts
);

	import txc_pkg::*;

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int EXTW       = (AW > IDX_W) ? AW : IDX_W;
	localparam int PAD_W      = M_DATA_W - POS_W - CELL_W;

	localparam logic [AW-1:0]    LAST_ROW_START = AW'(CELL_COUNT - COLUMNS);
	localparam logic [AW-1:0]    COPY_END       = AW'(CELL_COUNT - COLUMNS - 1);
	localparam logic [AW-1:0]    CELL_END       = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0]    COL_STEP       = AW'(COLUMNS);
	localparam logic [COL_W-1:0] COL_MAX        = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_MAX        = ROW_W'(ROWS - 1);
	localparam logic [EXTW-1:0]  CELL_LIMIT     = EXTW'(CELL_COUNT);

	// Item registers
	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [IDX_W-1:0]  idx_q;

	// Attribute register
	logic [ATTR_W-1:0] attr_q;

	// Cursor as linear index plus row and column
	logic [AW-1:0]    cursor_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Sweep / copy address and pending copy write
	logic [AW-1:0] addr_q;
	logic          cp_valid_s1;
	logic [AW-1:0] cp_addr_s1;

	// Result register
	logic [POS_W-1:0]  out_pos_q;
	logic [CELL_W-1:0] out_data_q;

	// RAM port signals
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic            is_nl;
	logic            is_bs;
	logic            cursor_zero;
	logic [EXTW-1:0] cur_ext;
	logic [EXTW-1:0] idx_ext;
	logic            idx_ok;

	assign is_nl       = (ch_q == CHAR_NL);
	assign is_bs       = (ch_q == CHAR_BS);
	assign cursor_zero = (cursor_q == '0);
	assign cur_ext     = EXTW'(cursor_q);
	assign idx_ext     = EXTW'(idx_q);
	assign idx_ok      = (idx_ext < CELL_LIMIT);

	// Status to the controller
	assign sts.in_op      = s_tuser;
	assign sts.put_wraps  = (row_q == ROW_MAX) && (is_nl || (!is_bs && col_q == COL_MAX));
	assign sts.copy_last  = (addr_q == COPY_END);
	assign sts.sweep_last = (addr_q == CELL_END);

	// Attribute register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= s_tuser;
			ch_q  <= s_tdata[CHAR_W-1:0];
			idx_q <= s_tdata[CHAR_W +: IDX_W];
		end
	end

	// Cursor update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (ctl.load) begin
			if (s_tuser == OP_CLEAR) begin
				cursor_q <= '0;
				col_q    <= '0;
				row_q    <= '0;
			end
		end else if (ctl.put) begin
			if (sts.put_wraps) begin
				// scroll follows: cursor to start of the last row
				cursor_q <= LAST_ROW_START;
				col_q    <= '0;
				row_q    <= ROW_MAX;
			end else if (is_nl) begin
				cursor_q <= cursor_q + COL_STEP - AW'(col_q);
				col_q    <= '0;
				row_q    <= row_q + 1'b1;
			end else if (is_bs) begin
				if (!cursor_zero) begin
					cursor_q <= cursor_q - 1'b1;
					if (col_q == '0) begin
						col_q <= COL_MAX;
						row_q <= row_q - 1'b1;
					end else begin
						col_q <= col_q - 1'b1;
					end
				end
			end else begin
				cursor_q <= cursor_q + 1'b1;
				if (col_q == COL_MAX) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Sweep / copy address and copy write pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			cp_valid_s1 <= 1'b0;
		end else begin
			cp_valid_s1 <= ctl.copy;
			if (ctl.load) begin
				addr_q <= '0;
			end else if (ctl.copy || ctl.sweep) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.copy) begin
			cp_addr_s1 <= addr_q;
		end
	end

	// Write port selection; a pending copy write has the port to itself
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = BLANK_CELL;
		if (cp_valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = ram_rdata;
		end else if (ctl.sweep) begin
			ram_we    = 1'b1;
		end else if (ctl.put && !is_nl) begin
			if (is_bs) begin
				ram_we    = !cursor_zero;
				ram_waddr = cursor_q - 1'b1;
			end else begin
				ram_we    = 1'b1;
				ram_waddr = cursor_q;
				ram_wdata = {attr_q, ch_q};
			end
		end
	end

	// Read port: source row during scroll, else the requested cell
	assign ram_raddr = ctl.copy ? (addr_q + COL_STEP) : idx_ext[AW-1:0];

	txc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_pos_q  <= cur_ext[POS_W-1:0];
			out_data_q <= (op_q == OP_READ && idx_ok) ? ram_rdata : '0;
		end
	end

	assign m_tdata = {{PAD_W{1'b0}}, out_data_q, out_pos_q};

endmodule

FILE: design/txc_controller.sv
`timescale 1ns / 1ps

module txc_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output txc_pkg::txc_ctl_t ctl,
	input  txc_pkg::txc_sts_t sts
);

	import txc_pkg::*;

	typedef enum logic [7:0] {
		S_INIT  = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_PUT   = 8'b0000_0100,
		S_COPY  = 8'b0000_1000,
		S_DRAIN = 8'b0001_0000,
		S_BLANK = 8'b0010_0000,
		S_READ  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} txc_state_t;

	txc_state_t state_q;
	txc_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_INIT: begin
				ctl.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					case (sts.in_op)
						OP_PUT:   state_d = S_PUT;
						OP_CLEAR: state_d = S_BLANK;
						OP_READ:  state_d = S_READ;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_PUT: begin
				ctl.put = 1'b1;
				state_d = sts.put_wraps ? S_COPY : S_DONE;
			end
			S_COPY: begin
				ctl.copy = 1'b1;
				if (sts.copy_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last copy write takes the port
				state_d = S_BLANK;
			end
			S_BLANK: begin
				ctl.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

FILE: design/text_console_writer_top.sv
// Text console writer: cursor-driven writes into a COLUMNS x ROWS cell store.
// Every result carries the cursor; an in-range read adds its cell, other items a zero cell.
// A put that scrolls copies each row up through the one write port and one read port
// of the screen RAM, then blanks the last row; clear blanks the whole store.
// Items are taken one at a time: tready is high only while idle.
// Reset: a pass over all COLUMNS*ROWS cells (2000 by default) blanks the store, tready low.
`timescale 1ns / 1ps

`include "text_console_writer_top_macros.svh"

module text_console_writer_top #(
	parameter int COLUMNS = txc_pkg::COLUMNS_DEF,
	parameter int ROWS    = txc_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [txc_pkg::S_DATA_W-1:0] s_tdata,  // char_code[7:0], read_index[18:8]
	input  logic [txc_pkg::OP_W-1:0]     s_tuser,  // op[1:0]
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [txc_pkg::M_DATA_W-1:0] m_tdata,  // cursor_pos[10:0], read_data[26:11]
	// attribute register write
	input  logic                         cfg_we,
	input  logic [txc_pkg::ATTR_W-1:0]   cfg_wdata
);

	import txc_pkg::*;

	txc_ctl_t ctl;
	txc_sts_t sts;

	// Sequencer
	txc_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// Cursor, screen store and result register
	txc_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tdata   (m_tdata),
		.ctl       (ctl),
		.sts       (sts)
	);

	// No store activity while waiting for an item
	`TXC_ASSERT_NOW(a_idle_quiet, clk, arst_n, s_tready, !(ctl.put || ctl.copy || ctl.sweep))
	// At most one datapath command per cycle
	`TXC_ASSERT_NOW(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(ctl))
	// A scroll copy never returns straight to idle
	`TXC_ASSERT_NEXT(a_copy_busy, clk, arst_n, ctl.copy, !s_tready)
	// A loaded result is presented on the next cycle
	`TXC_ASSERT_NEXT(a_result_shown, clk, arst_n, ctl.out_load, m_tvalid)

endmodule
